@@ rtl/rect_subtract_clip_defines.svh @@
// Assertion macros shared by the rectangle subtraction RTL.
`ifndef RECT_SUBTRACT_CLIP_DEFINES_SVH
`define RECT_SUBTRACT_CLIP_DEFINES_SVH

`ifndef ASSERT_OFF
`define RSC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("implication check failed");
`define RSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define RSC_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define RSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ rtl/rsc_pkg.sv @@
// Package with widths and the piece type for rectangle subtraction.
package rsc_pkg;

	localparam int COORD_BITS = 16;
	localparam int SIZE_BITS  = COORD_BITS - 1;
	// Edges plus sizes need two extra bits for a signed compare without overflow
	localparam int WIDE_BITS  = COORD_BITS + 2;
	localparam int NUM_PIECES = 4;
	localparam int SEL_BITS   = $clog2(NUM_PIECES);

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic        [SIZE_BITS-1:0]  w;
		logic        [SIZE_BITS-1:0]  h;
	} piece_t;

	typedef logic signed [WIDE_BITS-1:0] wide_t;

endpackage

@@ rtl/rect_subtract_clip.sv @@
// Rectangle subtraction: source minus clip as up to four pieces (top, left, right, bottom).
// An accepted input passes through the input register and then the piece buffer before its first piece is offered.
// Throughput: one piece per cycle while out_ready is high; each input yields 1 to 4 pieces,
// drained through the single result port from the four-entry piece buffer.
// A new input is taken while the previous one drains its final piece.
// Reset (arst_n low) empties the input register and the piece buffer at once.
`include "rect_subtract_clip_defines.svh"

module rect_subtract_clip (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [rsc_pkg::COORD_BITS-1:0]  src_x,
	input  logic signed [rsc_pkg::COORD_BITS-1:0]  src_y,
	input  logic        [rsc_pkg::SIZE_BITS-1:0]   src_w,
	input  logic        [rsc_pkg::SIZE_BITS-1:0]   src_h,
	input  logic signed [rsc_pkg::COORD_BITS-1:0]  clip_x,
	input  logic signed [rsc_pkg::COORD_BITS-1:0]  clip_y,
	input  logic        [rsc_pkg::SIZE_BITS-1:0]   clip_w,
	input  logic        [rsc_pkg::SIZE_BITS-1:0]   clip_h,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [rsc_pkg::COORD_BITS-1:0]  piece_x,
	output logic signed [rsc_pkg::COORD_BITS-1:0]  piece_y,
	output logic        [rsc_pkg::SIZE_BITS-1:0]   piece_w,
	output logic        [rsc_pkg::SIZE_BITS-1:0]   piece_h,
	output logic                                   empty_res,
	output logic                                   last
);

	localparam int CB = rsc_pkg::COORD_BITS;
	localparam int SB = rsc_pkg::SIZE_BITS;
	localparam int WB = rsc_pkg::WIDE_BITS;
	localparam int NP = rsc_pkg::NUM_PIECES;

	// Input register
	logic                 valid_s1;
	logic signed [CB-1:0] sx_s1, sy_s1, cx_s1, cy_s1;
	logic        [SB-1:0] sw_s1, sh_s1, cw_s1, ch_s1;

	// Piece buffer
	rsc_pkg::piece_t      pieces_q [NP];
	logic [NP-1:0]        mask_q;
	logic                 empty_q;

	logic                 in_fire, out_fire, load;
	logic                 sel_last;
	logic [rsc_pkg::SEL_BITS-1:0] sel;

	rsc_pkg::wide_t sx, sy, sw, sh, cx, cy, cw, ch;
	rsc_pkg::wide_t sr, sb, cr, cbot;
	rsc_pkg::wide_t ix, iy, ir, ib, iw, ih;
	logic            contained, disjoint;
	rsc_pkg::piece_t calc [NP];
	logic [NP-1:0]   calc_mask;
	logic            calc_empty;

	assign sx = {{(WB-CB){sx_s1[CB-1]}}, sx_s1};
	assign sy = {{(WB-CB){sy_s1[CB-1]}}, sy_s1};
	assign cx = {{(WB-CB){cx_s1[CB-1]}}, cx_s1};
	assign cy = {{(WB-CB){cy_s1[CB-1]}}, cy_s1};
	assign sw = {{(WB-SB){1'b0}}, sw_s1};
	assign sh = {{(WB-SB){1'b0}}, sh_s1};
	assign cw = {{(WB-SB){1'b0}}, cw_s1};
	assign ch = {{(WB-SB){1'b0}}, ch_s1};

	assign sr   = sx + sw;
	assign sb   = sy + sh;
	assign cr   = cx + cw;
	assign cbot = cy + ch;

	assign ix = (sx >= cx)  ? sx : cx;
	assign iy = (sy >= cy)  ? sy : cy;
	assign ir = (sr <= cr)  ? sr : cr;
	assign ib = (sb <= cbot) ? sb : cbot;
	assign iw = ir - ix;
	assign ih = ib - iy;

	assign contained = (sx >= cx) && (sy >= cy) && (sr <= cr) && (sb <= cbot);
	assign disjoint  = (iw <= 0) || (ih <= 0);

	always_comb begin
		rsc_pkg::wide_t top_h, left_w, right_w, bot_h;
		top_h   = iy - sy;
		left_w  = ix - sx;
		right_w = sr - ir;
		bot_h   = sb - ib;
		calc[0] = '{x: sx_s1, y: sy_s1, w: sw_s1, h: top_h[SB-1:0]};
		calc[1] = '{x: sx_s1, y: iy[CB-1:0], w: left_w[SB-1:0], h: ih[SB-1:0]};
		calc[2] = '{x: ir[CB-1:0], y: iy[CB-1:0], w: right_w[SB-1:0], h: ih[SB-1:0]};
		calc[3] = '{x: sx_s1, y: ib[CB-1:0], w: sw_s1, h: bot_h[SB-1:0]};
		calc_mask  = {ib < sb, ir < sr, ix > sx, iy > sy};
		calc_empty = 1'b0;
		if (contained) begin
			calc[0]    = '0;
			calc_mask  = NP'(1);
			calc_empty = 1'b1;
		end else if (disjoint) begin
			calc[0]   = '{x: sx_s1, y: sy_s1, w: sw_s1, h: sh_s1};
			calc_mask = NP'(1);
		end else if (calc_mask == '0) begin
			// no piece left over: report one empty transaction
			calc[0]    = '0;
			calc_mask  = NP'(1);
			calc_empty = 1'b1;
		end
	end

	// Pick the lowest pending piece
	always_comb begin
		sel = '0;
		for (int i = NP - 1; i >= 0; i--) begin
			if (mask_q[i]) sel = i[rsc_pkg::SEL_BITS-1:0];
		end
	end

	assign sel_last  = (mask_q & (mask_q - NP'(1))) == '0;
	assign out_valid = |mask_q;
	assign out_fire  = out_valid && out_ready;
	assign load      = valid_s1 && (!out_valid || (out_fire && sel_last));
	assign in_ready  = !valid_s1 || load;
	assign in_fire   = in_valid && in_ready;

	assign piece_x   = pieces_q[sel].x;
	assign piece_y   = pieces_q[sel].y;
	assign piece_w   = pieces_q[sel].w;
	assign piece_h   = pieces_q[sel].h;
	assign empty_res = empty_q;
	assign last      = sel_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			sx_s1 <= src_x;
			sy_s1 <= src_y;
			sw_s1 <= src_w;
			sh_s1 <= src_h;
			cx_s1 <= clip_x;
			cy_s1 <= clip_y;
			cw_s1 <= clip_w;
			ch_s1 <= clip_h;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q  <= '0;
			empty_q <= 1'b0;
		end else if (load) begin
			mask_q  <= calc_mask;
			empty_q <= calc_empty;
		end else if (out_fire) begin
			// drop the piece just sent
			mask_q  <= mask_q & (mask_q - NP'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < NP; i++) pieces_q[i] <= calc[i];
		end
	end

	`RSC_ASSERT_IMPL(a_empty_alone, clk, arst_n, out_valid && empty_q, mask_q == NP'(1))
	`RSC_ASSERT_IMPL(a_no_early_load, clk, arst_n, valid_s1 && out_valid && !(out_fire && sel_last), !in_ready)
	`RSC_ASSERT_NEXT(a_more_after_not_last, clk, arst_n, out_fire && !sel_last, out_valid)

endmodule
